// ===== design/next_fit_region_allocator_core_defines.svh =====
// Assertion macros shared by the allocator checker.
`ifndef NEXT_FIT_REGION_ALLOCATOR_CORE_DEFINES_SVH
`define NEXT_FIT_REGION_ALLOCATOR_CORE_DEFINES_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define NFRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Assert that an antecedent implies a consequent in the same cycle.
`define NFRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

// ===== design/nfra_pkg.sv =====
// Package with types and constants of the next-fit region allocator.
package nfra_pkg;
    localparam int TableEntries = 16;
    localparam int AddrBits     = 16;
    localparam int IdxBits      = $clog2(TableEntries);
    localparam int CntBits      = $clog2(TableEntries + 1);
    localparam int LenBits      = AddrBits + 1;
    localparam logic [AddrBits-1:0] ArenaReset = AddrBits'(1024);

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StNoFit   = 2'd1;
    localparam logic [1:0] StBadFree = 2'd2;
    localparam logic [1:0] StFull    = 2'd3;

    typedef struct packed {
        logic [AddrBits-1:0] start;
        logic [LenBits-1:0]  len;
    } region_t;

    // Request from control to the table memory.
    typedef struct packed {
        logic                re;
        logic [IdxBits-1:0]  raddr;
        logic                we;
        logic [IdxBits-1:0]  waddr;
        region_t             wdata;
    } mem_req_t;
endpackage

// ===== design/nfra_table_mem.sv =====
// Region table memory: one write port, one registered read port.
module nfra_table_mem (
    input  logic                  clk,
    input  nfra_pkg::mem_req_t    req,
    output nfra_pkg::region_t     rdata
);
    nfra_pkg::region_t mem [nfra_pkg::TableEntries];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end
endmodule

// ===== design/nfra_ctrl.sv =====
// Sequencer: scans, shifts and rewrites the region table for each request.
module nfra_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [nfra_pkg::AddrBits-1:0]  cfg_data,
    output logic                           cfg_ready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_type,
    input  logic [nfra_pkg::AddrBits-1:0]  in_size,
    input  logic [nfra_pkg::AddrBits-1:0]  in_addr,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     out_status,
    output logic [nfra_pkg::AddrBits-1:0]  out_addr,
    output nfra_pkg::mem_req_t             mreq,
    input  nfra_pkg::region_t              mrd
);
    localparam int IB = nfra_pkg::IdxBits;
    localparam int CB = nfra_pkg::CntBits;
    localparam int AB = nfra_pkg::AddrBits;
    localparam int LB = nfra_pkg::LenBits;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_AREAD = 10'b0000000010,
        S_ACHK  = 10'b0000000100,
        S_FREAD = 10'b0000001000,
        S_FCHK  = 10'b0000010000,
        S_REM   = 10'b0000100000,
        S_REMW  = 10'b0001000000,
        S_INS   = 10'b0010000000,
        S_INSW  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [AB-1:0]      arena_reg, arena_next;
    logic [CB-1:0]      count_reg, count_next;
    logic [IB-1:0]      ptr_reg, ptr_next;
    logic [CB-1:0]      scan_reg, scan_next;   // entries visited / scan index
    logic [IB-1:0]      idx_reg, idx_next;
    logic [AB-1:0]      size_reg, size_next;
    logic [AB-1:0]      addr_reg, addr_next;
    logic [CB-1:0]      pos_reg, pos_next;
    logic               lower_reg, lower_next;
    logic [LB-1:0]      lowlen_reg, lowlen_next;
    logic [IB-1:0]      sh_reg, sh_next;       // shift cursor
    nfra_pkg::region_t  pend_reg, pend_next;   // entry to place after shift
    logic               ovl_reg, ovl_next;
    logic               ovalid_reg, ovalid_next;
    logic [1:0]         ostat_reg, ostat_next;
    logic [AB-1:0]      oaddr_reg, oaddr_next;

    logic [LB:0]        end_w;      // addr + size
    logic [LB:0]        rend_w;     // region end
    logic [LB-1:0]      size_ext;

    assign size_ext = LB'(size_reg);
    assign end_w    = (LB+1)'(addr_reg) + (LB+1)'(size_reg);
    assign rend_w   = (LB+1)'(mrd.start) + (LB+1)'(mrd.len);

    assign cfg_ready  = (state_reg == S_IDLE);
    assign in_ready   = (state_reg == S_IDLE) && !ovalid_reg && !cfg_valid;
    assign out_valid  = ovalid_reg;
    assign out_status = ostat_reg;
    assign out_addr   = oaddr_reg;

    always_comb
    begin
        state_next  = state_reg;
        arena_next  = arena_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        scan_next   = scan_reg;
        idx_next    = idx_reg;
        size_next   = size_reg;
        addr_next   = addr_reg;
        pos_next    = pos_reg;
        lower_next  = lower_reg;
        lowlen_next = lowlen_reg;
        sh_next     = sh_reg;
        pend_next   = pend_reg;
        ovl_next    = ovl_reg;
        ovalid_next = ovalid_reg;
        ostat_next  = ostat_reg;
        oaddr_next  = oaddr_reg;
        mreq        = '0;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    arena_next     = cfg_data;
                    ptr_next       = '0;
                    count_next     = (cfg_data != '0) ? CB'(1) : '0;
                    mreq.we        = 1'b1;
                    mreq.waddr     = '0;
                    mreq.wdata     = '{start: '0, len: LB'(cfg_data)};
                end
                else if (in_valid && in_ready)
                begin
                    size_next  = in_size;
                    addr_next  = in_addr;
                    ostat_next = nfra_pkg::StNoFit;
                    oaddr_next = '0;
                    scan_next  = '0;
                    pos_next   = '0;
                    lower_next = 1'b0;
                    ovl_next   = 1'b0;
                    if (!in_type)
                    begin
                        if (in_size == '0 || count_reg == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next   = (CB'(ptr_reg) >= count_reg) ? '0 : ptr_reg;
                            ptr_next   = (CB'(ptr_reg) >= count_reg) ? '0 : ptr_reg;
                            state_next = S_AREAD;
                        end
                    end
                    else
                    begin
                        ostat_next = nfra_pkg::StBadFree;
                        if (in_size == '0 ||
                            ((LB+1)'(in_addr) + (LB+1)'(in_size)) > (LB+1)'(arena_reg))
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_FREAD;
                        end
                    end
                end
            end
            S_AREAD:
            begin
                mreq.re    = 1'b1;
                mreq.raddr = idx_reg;
                state_next = S_ACHK;
            end
            S_ACHK:
            begin
                if (mrd.len > size_ext)
                begin
                    oaddr_next = mrd.start;
                    ostat_next = nfra_pkg::StOk;
                    mreq.we    = 1'b1;
                    mreq.waddr = idx_reg;
                    mreq.wdata = '{start: mrd.start + size_reg, len: mrd.len - size_ext};
                    ptr_next   = idx_reg;
                    state_next = S_DONE;
                end
                else if (mrd.len == size_ext)
                begin
                    oaddr_next = mrd.start;
                    ostat_next = nfra_pkg::StOk;
                    ptr_next   = (CB'(idx_reg) + CB'(1) < count_reg) ? idx_reg : '0;
                    sh_next    = idx_reg;
                    state_next = S_REM;
                end
                else if (scan_reg + CB'(1) >= count_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    scan_next  = scan_reg + CB'(1);
                    idx_next   = (CB'(idx_reg) + CB'(1) >= count_reg) ? '0 : idx_reg + IB'(1);
                    state_next = S_AREAD;
                end
            end
            S_FREAD:
            begin
                if (scan_reg >= count_reg)
                begin
                    // Scan done: finish on overlap, else read entry pos to decide merge or insert.
                    if (ovl_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mreq.re    = 1'b1;
                        mreq.raddr = IB'(pos_reg);
                        state_next = S_FCHK;
                        scan_next  = count_reg + CB'(1);
                    end
                end
                else
                begin
                    mreq.re    = 1'b1;
                    mreq.raddr = IB'(scan_reg);
                    state_next = S_FCHK;
                end
            end
            S_FCHK:
            begin
                if (scan_reg <= count_reg && scan_reg < count_reg)
                begin
                    if ((LB+1)'(mrd.start) < end_w && (LB+1)'(addr_reg) < rend_w)
                    begin
                        ovl_next = 1'b1;
                    end
                    if (mrd.start < addr_reg)
                    begin
                        pos_next    = scan_reg + CB'(1);
                        lower_next  = (rend_w == (LB+1)'(addr_reg));
                        lowlen_next = mrd.len;
                    end
                    scan_next  = scan_reg + CB'(1);
                    state_next = S_FREAD;
                end
                else
                begin
                    // mrd holds entry pos (valid only if pos < count).
                    if (lower_reg && pos_reg < count_reg &&
                        (LB+1)'(mrd.start) == end_w)
                    begin
                        mreq.we    = 1'b1;
                        mreq.waddr = IB'(pos_reg - CB'(1));
                        mreq.wdata = '{start: AB'(addr_reg - AB'(lowlen_reg)),
                                       len: lowlen_reg + size_ext + mrd.len};
                        if (CB'(ptr_reg) >= pos_reg)
                        begin
                            ptr_next = ptr_reg - IB'(1);
                        end
                        sh_next    = IB'(pos_reg);
                        ostat_next = nfra_pkg::StOk;
                        state_next = S_REM;
                    end
                    else if (lower_reg)
                    begin
                        mreq.we    = 1'b1;
                        mreq.waddr = IB'(pos_reg - CB'(1));
                        mreq.wdata = '{start: AB'(addr_reg - AB'(lowlen_reg)),
                                       len: lowlen_reg + size_ext};
                        ostat_next = nfra_pkg::StOk;
                        state_next = S_DONE;
                    end
                    else if (pos_reg < count_reg && (LB+1)'(mrd.start) == end_w)
                    begin
                        mreq.we    = 1'b1;
                        mreq.waddr = IB'(pos_reg);
                        mreq.wdata = '{start: addr_reg, len: mrd.len + size_ext};
                        ostat_next = nfra_pkg::StOk;
                        state_next = S_DONE;
                    end
                    else if (count_reg >= CB'(nfra_pkg::TableEntries))
                    begin
                        ostat_next = nfra_pkg::StFull;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            ptr_next = '0;
                        end
                        else if (pos_reg <= CB'(ptr_reg))
                        begin
                            ptr_next = ptr_reg + IB'(1);
                        end
                        pend_next  = '{start: addr_reg, len: size_ext};
                        sh_next    = IB'(count_reg);
                        ostat_next = nfra_pkg::StOk;
                        state_next = S_INS;
                    end
                end
            end
            S_REM:
            begin
                // Move entry sh+1 down to sh until the end of the table.
                if (CB'(sh_reg) + CB'(1) >= count_reg)
                begin
                    count_next = count_reg - CB'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    mreq.re    = 1'b1;
                    mreq.raddr = sh_reg + IB'(1);
                    state_next = S_REMW;
                end
            end
            S_REMW:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = sh_reg;
                mreq.wdata = mrd;
                sh_next    = sh_reg + IB'(1);
                state_next = S_REM;
            end
            S_INS:
            begin
                // Move entry sh-1 up to sh down to pos, then place the new one.
                if (CB'(sh_reg) <= pos_reg)
                begin
                    mreq.we    = 1'b1;
                    mreq.waddr = sh_reg;
                    mreq.wdata = pend_reg;
                    count_next = count_reg + CB'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    mreq.re    = 1'b1;
                    mreq.raddr = sh_reg - IB'(1);
                    state_next = S_INSW;
                end
            end
            S_INSW:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = sh_reg;
                mreq.wdata = mrd;
                sh_next    = sh_reg - IB'(1);
                state_next = S_INS;
            end
            S_DONE:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            arena_reg  <= nfra_pkg::ArenaReset;
            count_reg  <= CB'(1);
            ptr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            arena_reg  <= arena_next;
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg   <= scan_next;
        idx_reg    <= idx_next;
        size_reg   <= size_next;
        addr_reg   <= addr_next;
        pos_reg    <= pos_next;
        lower_reg  <= lower_next;
        lowlen_reg <= lowlen_next;
        sh_reg     <= sh_next;
        pend_reg   <= pend_next;
        ovl_reg    <= ovl_next;
        ostat_reg  <= ostat_next;
        oaddr_reg  <= oaddr_next;
    end
endmodule

// ===== design/nfra_reset_seed.sv =====
// Seeds entry 0 of the region table right after reset.
module nfra_reset_seed (
    input  logic                clk,
    input  logic                rst_n,
    input  nfra_pkg::mem_req_t  ctrl_req,
    output nfra_pkg::mem_req_t  mem_req,
    output logic                busy
);
    logic seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 1'b1;
        end
        else
        begin
            seed_reg <= 1'b0;
        end
    end

    assign busy = seed_reg;

    always_comb
    begin
        mem_req = ctrl_req;
        if (seed_reg)
        begin
            mem_req.we    = 1'b1;
            mem_req.waddr = '0;
            mem_req.wdata = '{start: '0, len: nfra_pkg::LenBits'(nfra_pkg::ArenaReset)};
        end
    end
endmodule

// ===== design/next_fit_region_allocator_core.sv =====
// Top level of the next-fit region allocator with coalescing.
//
//  channel   | dir | handshake                  | payload
//  s_axis    | in  | s_axis_tvalid/tready       | tdata: req_size, req_addr; tuser: req_type
//  m_axis    | out | m_axis_tvalid/tready       | tdata: status, alloc_addr
//  cfg       | in  | cfg_valid/cfg_ready        | cfg_data: arena_size
//
// Work: an allocate reads and checks the table entries one at a time from the
// next-fit pointer; a free reads every entry, then the entry at its place; an
// insert or a remove shifts entries one at a time, a read and then a write
// each. All of it is set by the one registered read port of the region memory.
// Reset: the first cycle after reset writes entry 0; no item or write is taken then.
// Stalls: a result waits in the output register; the next item is taken only
// after it has been delivered. Configuration is taken only while idle.
module next_fit_region_allocator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] req_size, [31:16] req_addr
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [1:0] status, [17:2] alloc_addr, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    nfra_pkg::mem_req_t ctrl_req, mem_req;
    nfra_pkg::region_t  rdata;
    logic               seed_busy;
    logic               c_ready;
    logic               c_cfg_ready;
    logic [1:0]         st;
    logic [15:0]        aa;

    // Hold configuration until the seed write of reset is out and the
    // sequencer is idle.
    assign cfg_ready     = c_cfg_ready && !seed_busy;
    assign s_axis_tready = c_ready && !seed_busy;

    nfra_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid && !seed_busy),
        .cfg_data   (cfg_data),
        .cfg_ready  (c_cfg_ready),
        .in_valid   (s_axis_tvalid && !seed_busy),
        .in_ready   (c_ready),
        .in_type    (s_axis_tuser),
        .in_size    (s_axis_tdata[15:0]),
        .in_addr    (s_axis_tdata[31:16]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (st),
        .out_addr   (aa),
        .mreq       (ctrl_req),
        .mrd        (rdata)
    );

    nfra_reset_seed u_seed (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_req (ctrl_req),
        .mem_req  (mem_req),
        .busy     (seed_busy)
    );

    nfra_table_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    assign m_axis_tdata = {6'd0, aa, st};
endmodule

// ===== design/nfra_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
`include "next_fit_region_allocator_core_defines.svh"
module nfra_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready
);
    `NFRA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
    `NFRA_ASSERT_NOW(a_no_take_with_result, s_axis_tready, !m_axis_tvalid, "item taken while result pending")
    `NFRA_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken during work")
    `NFRA_ASSERT_NOW(a_fail_addr_zero, m_axis_tvalid && m_axis_tdata[1:0] != 2'd0, m_axis_tdata[17:2] == 16'd0, "failed request with nonzero address")
    `NFRA_ASSERT_NOW(a_cfg_when_idle, s_axis_tready, cfg_ready && !cfg_valid, "item taken beside a configuration write")
endmodule

bind next_fit_region_allocator_core nfra_checker u_nfra_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);
